>>> sv/rv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv_pkg - shared types and constants for the rolling volatility core
// field widths, register map, reset values and the sequencer state type
// ----------------------------------------------------------------------------
package rv_pkg;

    // field widths
    localparam int SAMPLE_W = 24;   // signed q1.22 return sample
    localparam int VOL_W    = 24;   // unsigned q2.22 volatility
    localparam int CFG_W    = 11;   // window_length register

    // default window storage depth
    localparam int MAX_WINDOW_DEFAULT = 1024;

    // register port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 11'd20;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_ADD_NEW,
        ST_SUB_OLD,
        ST_MUL_SQ,
        ST_MUL_WQ,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } rv_state_t;

endpackage

>>> sv/rv_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv_serial_mul - bit-serial unsigned multiplier
// shift-add, one multiplier bit per cycle, stops once the rest is zero
// ----------------------------------------------------------------------------
module rv_serial_mul #(
    parameter int A_W = 58,
    parameter int B_W = 35,
    parameter int P_W = 69
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           done,
    output logic [P_W-1:0] product
);

    logic           busy_reg;
    logic           done_reg;
    logic [P_W-1:0] mcand_reg;
    logic [B_W-1:0] mplier_reg;
    logic [P_W-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (mplier_reg == '0)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg  <= P_W'(a);
            mplier_reg <= b;
            acc_reg    <= '0;
        end else if (busy_reg && (mplier_reg != '0)) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> sv/rv_serial_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv_serial_sqrt - restoring integer square root
// one root bit per cycle, floor(sqrt(radicand))
// ----------------------------------------------------------------------------
module rv_serial_sqrt #(
    parameter int N_W = 69,
    parameter int R_W = (N_W + 1) / 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] radicand,
    output logic           done,
    output logic [R_W-1:0] root
);

    localparam int CW = $clog2(R_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [2*R_W-1:0] rad_reg;
    logic [R_W+1:0]   rem_reg;
    logic [R_W-1:0]   root_reg;

    logic [R_W+3:0] rem_sh;
    logic [R_W+3:0] trial;
    logic [R_W+3:0] diff;
    logic           take;

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_reg, rad_reg[2*R_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign diff   = rem_sh - trial;
    assign take   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(R_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= (2*R_W)'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= take ? diff[R_W+1:0] : rem_sh[R_W+1:0];
            root_reg <= {root_reg[R_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> sv/rv_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv_serial_div - restoring unsigned divider
// one quotient bit per cycle, quotient shifts in behind the dividend
// ----------------------------------------------------------------------------
module rv_serial_div #(
    parameter int D_W = 35,
    parameter int V_W = 11
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [D_W-1:0] dividend,
    input  logic [V_W-1:0] divisor,
    output logic           done,
    output logic [D_W-1:0] quotient
);

    localparam int CW = $clog2(D_W + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [CW-1:0]  cnt_reg;
    logic [D_W-1:0] dvd_reg;
    logic [V_W-1:0] dvs_reg;
    logic [V_W-1:0] rem_reg;

    logic [V_W:0] rem_sh;
    logic [V_W:0] diff;
    logic         take;

    assign rem_sh = {rem_reg, dvd_reg[D_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign take   = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(D_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= take ? diff[V_W-1:0] : rem_sh[V_W-1:0];
            dvd_reg <= {dvd_reg[D_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

>>> sv/rolling_volatility_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_volatility_core - population standard deviation over a sliding window
// takes q1.22 return samples, returns the q2.22 deviation of the last W words
// ----------------------------------------------------------------------------
// sequencing: while the window fills a sample gives no result word; once the
//   window is full each sample also runs the bit-serial multiply, square root
//   and divide, one bit per cycle each
// throughput: one sample at a time, the next is taken once the word is parked
// reset: synchronous active-low aresetn; window_length 20, pointer, fill, sums clear
// ----------------------------------------------------------------------------
module rolling_volatility_core #(
    parameter int MAX_WINDOW = rv_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // sample input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [rv_pkg::SAMPLE_W-1:0] s_return_sample,

    // result output
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rv_pkg::VOL_W-1:0]        m_volatility,

    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rv_pkg::ADDR_W-1:0]       paddr,
    input  logic [rv_pkg::DATA_W-1:0]       pwdata,
    output logic [rv_pkg::DATA_W-1:0]       prdata,
    output logic                            pready
);

    // widths that follow from the window depth
    localparam int SW    = rv_pkg::SAMPLE_W;
    localparam int WW    = $clog2(MAX_WINDOW + 1);            // active window count
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int IW    = WW + 1;                            // index arithmetic
    localparam int SUM_W = SW + WW;                           // signed running sum
    localparam int PSQ_W = 2*SW - 1;                          // one squared sample
    localparam int SQ_W  = PSQ_W + WW;                        // running sum of squares
    localparam int N_W   = PSQ_W + 2*WW;                      // W*sumsq - sum^2
    localparam int R_W   = (N_W + 1) / 2;                     // sqrt of that

    // ------------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------------
    logic [rv_pkg::CFG_W-1:0] window_length_reg;
    logic                     reg_hit;
    logic                     cfg_wr;

    assign reg_hit = (paddr[rv_pkg::ADDR_W-1:2] == rv_pkg::REG_WINDOW_LENGTH);
    assign cfg_wr  = psel && penable && pwrite && reg_hit;
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? rv_pkg::DATA_W'(window_length_reg) : '0;

    // active window: zero acts as one, anything past the depth acts as the depth
    logic [WW-1:0] w_act;
    always_comb begin
        if (window_length_reg == '0) begin
            w_act = WW'(1);
        end else if (32'(window_length_reg) > 32'(MAX_WINDOW)) begin
            w_act = WW'(MAX_WINDOW);
        end else begin
            w_act = WW'(window_length_reg);
        end
    end

    // ------------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------------
    rv_pkg::rv_state_t state_reg, state_next;

    logic [AW-1:0]           wp_reg;
    logic [WW-1:0]           fill_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]         sumsq_reg;

    logic signed [SW-1:0]    x_reg;          // sample being folded in
    logic signed [SW-1:0]    old_reg;        // sample leaving the window
    logic                    full_reg;       // window was full when x arrived
    logic [PSQ_W-1:0]        sq_reg;         // square of x, then of old
    logic [N_W-1:0]          sq_prod_reg;    // sum^2
    logic [rv_pkg::VOL_W-1:0] result_reg;
    logic                    m_valid_reg;
    logic [rv_pkg::VOL_W-1:0] m_volatility_reg;

    logic s_fire;
    assign s_ready = (state_reg == rv_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // ------------------------------------------------------------------------
    // sample history: read the leaving word at accept, write the new one next
    // ------------------------------------------------------------------------
    logic signed [SW-1:0] hist_mem [MAX_WINDOW];

    logic [IW-1:0] wp_ext;
    logic [IW-1:0] w_ext;
    logic [IW-1:0] idx_wide;
    logic [AW-1:0] old_idx;

    assign wp_ext   = IW'(wp_reg);
    assign w_ext    = IW'(w_act);
    assign idx_wide = (wp_ext >= w_ext) ? (wp_ext - w_ext)
                                        : (wp_ext + IW'(MAX_WINDOW) - w_ext);
    assign old_idx  = idx_wide[AW-1:0];

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            old_reg <= hist_mem[old_idx];
        end
        if (state_reg == rv_pkg::ST_ACCUM) begin
            hist_mem[wp_reg] <= x_reg;
        end
    end

    // ------------------------------------------------------------------------
    // running sums update
    // ------------------------------------------------------------------------
    logic signed [SW-1:0]     sq_in;
    logic signed [2*SW-1:0]   sq_full;
    logic signed [SW-1:0]     old_term;

    // one squarer, shared between the arriving and the leaving sample
    assign sq_in    = (state_reg == rv_pkg::ST_ACCUM) ? x_reg : old_reg;
    assign sq_full  = sq_in * sq_in;
    assign old_term = full_reg ? old_reg : '0;

    logic [WW-1:0] fill_upd;
    logic [AW-1:0] wp_upd;
    logic          result_due;

    assign fill_upd   = full_reg ? w_act : (fill_reg + WW'(1));
    assign wp_upd     = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : (wp_reg + AW'(1));
    assign result_due = (fill_upd == w_act);

    // ------------------------------------------------------------------------
    // bit-serial arithmetic units
    // ------------------------------------------------------------------------
    logic [SUM_W-1:0] sum_mag;
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    logic             mul_start;
    logic             mul_sel_wq;
    logic [SQ_W-1:0]  mul_a;
    logic [SUM_W-1:0] mul_b;
    logic             mul_done;
    logic [N_W-1:0]   mul_product;

    // first sum^2, then W * sumsq
    assign mul_a = mul_sel_wq ? sumsq_reg : SQ_W'(sum_mag);
    assign mul_b = mul_sel_wq ? SUM_W'(w_act) : sum_mag;

    rv_serial_mul #(
        .A_W (SQ_W),
        .B_W (SUM_W),
        .P_W (N_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    logic           var_ok;
    logic [N_W-1:0] var_num;
    assign var_ok  = (mul_product >= sq_prod_reg);
    assign var_num = mul_product - sq_prod_reg;

    logic           sqrt_start;
    logic           sqrt_done;
    logic [R_W-1:0] sqrt_root;

    rv_serial_sqrt #(
        .N_W (N_W),
        .R_W (R_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (var_num),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // s = floor(floor(sqrt(n)) / W), the largest s with (s*W)^2 <= n
    logic           div_start;
    logic           div_done;
    logic [R_W-1:0] div_quot;

    rv_serial_div #(
        .D_W (R_W),
        .V_W (WW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sqrt_root),
        .divisor  (w_act),
        .done     (div_done),
        .quotient (div_quot)
    );

    logic [rv_pkg::VOL_W-1:0] vol_sat;
    assign vol_sat = (div_quot[R_W-1:rv_pkg::VOL_W] != '0) ? '1
                                                          : div_quot[rv_pkg::VOL_W-1:0];

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_sel_wq = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            rv_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = rv_pkg::ST_ACCUM;
                end
            end
            rv_pkg::ST_ACCUM: begin
                state_next = rv_pkg::ST_ADD_NEW;
            end
            rv_pkg::ST_ADD_NEW: begin
                state_next = rv_pkg::ST_SUB_OLD;
            end
            rv_pkg::ST_SUB_OLD: begin
                // no word while the window is still filling
                if (result_due) begin
                    mul_start  = 1'b1;
                    state_next = rv_pkg::ST_MUL_SQ;
                end else begin
                    state_next = rv_pkg::ST_IDLE;
                end
            end
            rv_pkg::ST_MUL_SQ: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_sel_wq = 1'b1;
                    state_next = rv_pkg::ST_MUL_WQ;
                end
            end
            rv_pkg::ST_MUL_WQ: begin
                if (mul_done) begin
                    // negative variance goes straight out as zero
                    if (var_ok) begin
                        sqrt_start = 1'b1;
                        state_next = rv_pkg::ST_SQRT;
                    end else begin
                        state_next = rv_pkg::ST_OUT;
                    end
                end
            end
            rv_pkg::ST_SQRT: begin
                if (sqrt_done) begin
                    div_start  = 1'b1;
                    state_next = rv_pkg::ST_DIV;
                end
            end
            rv_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = rv_pkg::ST_OUT;
                end
            end
            rv_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = rv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rv_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= rv_pkg::ST_IDLE;
            window_length_reg <= rv_pkg::WINDOW_RESET;
            wp_reg            <= '0;
            fill_reg          <= '0;
            sum_reg           <= '0;
            sumsq_reg         <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr) begin
                // a new window length empties the window
                window_length_reg <= pwdata[rv_pkg::CFG_W-1:0];
                wp_reg            <= '0;
                fill_reg          <= '0;
                sum_reg           <= '0;
                sumsq_reg         <= '0;
            end else begin
                if (state_reg == rv_pkg::ST_ACCUM) begin
                    sum_reg <= sum_reg + SUM_W'(x_reg) - SUM_W'(old_term);
                end
                if (state_reg == rv_pkg::ST_ADD_NEW) begin
                    sumsq_reg <= sumsq_reg + SQ_W'(sq_reg);
                end
                if (state_reg == rv_pkg::ST_SUB_OLD) begin
                    sumsq_reg <= sumsq_reg - SQ_W'(sq_reg);
                    fill_reg  <= fill_upd;
                    wp_reg    <= wp_upd;
                end
            end

            // output register frees the core as soon as the word is parked
            if ((state_reg == rv_pkg::ST_OUT) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            x_reg    <= s_return_sample;
            full_reg <= (fill_reg >= w_act);
        end

        case (state_reg)
            rv_pkg::ST_ACCUM: begin
                sq_reg <= sq_full[PSQ_W-1:0];
            end
            rv_pkg::ST_ADD_NEW: begin
                sq_reg <= full_reg ? sq_full[PSQ_W-1:0] : '0;
            end
            default: begin
                sq_reg <= sq_reg;
            end
        endcase

        if ((state_reg == rv_pkg::ST_MUL_SQ) && mul_done) begin
            sq_prod_reg <= mul_product;
        end
        if ((state_reg == rv_pkg::ST_MUL_WQ) && mul_done && !var_ok) begin
            result_reg <= '0;
        end
        if ((state_reg == rv_pkg::ST_DIV) && div_done) begin
            result_reg <= vol_sat;
        end
        if ((state_reg == rv_pkg::ST_OUT) && (!m_valid_reg || m_ready)) begin
            m_volatility_reg <= result_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_volatility = m_volatility_reg;

endmodule
